// ===== hdl/lrct_pkg.sv =====
// Shared types, codes and constants of the learned-remote countdown timer.
package lrct_pkg;

    localparam int DEF_TABLE_ENTRIES = 8;

    localparam int OP_W    = 3;
    localparam int CODE_W  = 32;
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 16;
    localparam int DIGIT_W = 2;
    localparam int TO_W    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SETTING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORKING  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LEARNING = 2'd3;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_UP     = 3'd1;
    localparam logic [OP_W-1:0] OP_DOWN   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_PRESS  = 3'd4;
    localparam logic [OP_W-1:0] OP_LONG   = 3'd5;
    localparam logic [OP_W-1:0] OP_REMOTE = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_TIMEOUT = 4'd1;

    // 9:09:59 as the default clamp
    localparam logic [VALUE_W-1:0] MAX_DURATION_RST  = VALUE_W'(9 * 3600 + 9 * 60 + 59);
    localparam logic [TO_W-1:0]    LEARN_TIMEOUT_RST = TO_W'(30);

    // seconds per edited digit
    function automatic logic [VALUE_W-1:0] step_size(input logic [DIGIT_W-1:0] digit);
        logic [VALUE_W-1:0] s;
        case (digit)
            2'd0:    s = VALUE_W'(1);
            2'd1:    s = VALUE_W'(60);
            2'd2:    s = VALUE_W'(3600);
            default: s = VALUE_W'(36000);
        endcase
        return s;
    endfunction

    typedef struct packed {
        logic load;
        logic search_step;
        logic apply;
    } lrct_cmd_t;

    typedef struct packed {
        logic need_search;
        logic search_done;
    } lrct_status_t;

endpackage

// ===== hdl/lrct_ifs.sv =====
// Channel interfaces: event items in, result items out, register writes.
interface lrct_event_if import lrct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CODE_W-1:0] frame_code;
    modport source (output valid, output operation, output frame_code, input ready);
    modport sink   (input valid, input operation, input frame_code, output ready);
endinterface

interface lrct_result_if import lrct_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] shown_value;
    logic [DIGIT_W-1:0] blink_digit;
    logic               save_request;
    logic               code_matched;
    modport source (output valid, output mode, output shown_value, output blink_digit,
                    output save_request, output code_matched, input ready);
    modport sink   (input valid, input mode, input shown_value, input blink_digit,
                    input save_request, input code_matched, output ready);
endinterface

interface lrct_cfg_if import lrct_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hdl/lrct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lrct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/lrct_ctrl.sv =====
// Sequencer: accept, table search, apply and output register handshake.
module lrct_ctrl import lrct_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         out_ready,
    output logic         out_valid,
    input  lrct_status_t st,
    output lrct_cmd_t    cmd
);
    localparam logic [1:0] ST_WAIT   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_full_reg, out_full_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.need_search ? ST_SEARCH : ST_APPLY;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (st.search_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                // wait for the output register to free up
                if (!out_full_reg || out_ready)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_comb
    begin
        out_full_next = out_full_reg;
        if (cmd.apply)
        begin
            out_full_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_WAIT;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign out_valid = out_full_reg;
endmodule

// ===== hdl/lrct_datapath.sv =====
// Timer state, config registers, table search compare and result register.
module lrct_datapath import lrct_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrct_cmd_t             cmd,
    output lrct_status_t          st,
    input  logic [OP_W-1:0]       in_operation,
    input  logic [CODE_W-1:0]     in_frame_code,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  ram_we,
    output logic [SLOT_W-1:0]     ram_waddr,
    output logic [CODE_W-1:0]     ram_wdata,
    output logic [SLOT_W-1:0]     ram_raddr,
    input  logic [CODE_W-1:0]     ram_rdata,
    output logic [MODE_W-1:0]     out_mode,
    output logic [VALUE_W-1:0]    out_shown_value,
    output logic [DIGIT_W-1:0]    out_blink_digit,
    output logic                  out_save_request,
    output logic                  out_code_matched
);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);

    // config
    logic [VALUE_W-1:0] max_dur_reg;
    logic [TO_W-1:0]    timeout_reg;

    // timer state
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [VALUE_W-1:0] dur_reg, dur_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               edited_reg, edited_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               valid_reg [TABLE_ENTRIES];

    // latched item and search
    logic [OP_W-1:0]    op_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic               cmp_valid_reg;
    logic               cmp_last_reg;
    logic               cmp_entry_ok_reg;
    logic               match_reg;

    // result register
    logic [MODE_W-1:0]  res_mode_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic [DIGIT_W-1:0] res_digit_reg;
    logic               res_save_reg;
    logic               res_match_reg;

    logic               hit;
    logic [CODE_W-1:0]  entry;
    logic               save_next;
    logic               tbl_we;

    // never-written entries read as zero
    assign entry = cmp_entry_ok_reg ? ram_rdata : '0;
    assign hit   = cmp_valid_reg && (entry == code_reg);

    assign st.need_search = (in_operation == OP_REMOTE) && (mode_reg == MODE_IDLE);
    assign st.search_done = hit || (cmp_valid_reg && cmp_last_reg);

    always_comb
    begin
        logic [VALUE_W-1:0] step;
        logic [VALUE_W:0]   up_sum;
        logic               go;
        logic [MODE_W-1:0]  go_mode;

        step    = step_size(digit_reg);
        up_sum  = {1'b0, dur_reg} + {1'b0, step};
        go      = 1'b0;
        go_mode = mode_reg;

        mode_next   = mode_reg;
        dur_next    = dur_reg;
        rem_next    = rem_reg;
        digit_next  = digit_reg;
        edited_next = edited_reg;
        slot_next   = slot_reg;
        save_next   = 1'b0;
        tbl_we      = 1'b0;

        case (op_reg) inside
            OP_TICK:
            begin
                if (mode_reg == MODE_WORKING || mode_reg == MODE_LEARNING)
                begin
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - VALUE_W'(1);
                    end
                    else
                    begin
                        go      = 1'b1;
                        go_mode = MODE_IDLE;
                    end
                end
            end
            OP_UP:
            begin
                if (mode_reg == MODE_SETTING)
                begin
                    dur_next    = (up_sum <= {1'b0, max_dur_reg}) ? up_sum[VALUE_W-1:0]
                                                                  : max_dur_reg;
                    edited_next = 1'b1;
                end
            end
            OP_DOWN:
            begin
                if (mode_reg == MODE_SETTING)
                begin
                    dur_next    = (dur_reg >= step) ? (dur_reg - step) : '0;
                    edited_next = 1'b1;
                end
            end
            OP_CLICK:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    go      = 1'b1;
                    go_mode = MODE_WORKING;
                end
                else if (mode_reg == MODE_SETTING)
                begin
                    digit_next  = digit_reg + DIGIT_W'(1);
                    edited_next = 1'b1;
                end
            end
            OP_PRESS, OP_LONG:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    go      = 1'b1;
                    go_mode = (op_reg == OP_PRESS) ? MODE_SETTING : MODE_LEARNING;
                end
                else if (mode_reg == MODE_SETTING)
                begin
                    go      = 1'b1;
                    go_mode = MODE_IDLE;
                end
            end
            OP_REMOTE:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    go      = match_reg;
                    go_mode = MODE_WORKING;
                end
                else if (mode_reg == MODE_LEARNING)
                begin
                    slot_next   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                    tbl_we      = 1'b1;
                    edited_next = 1'b1;
                    go          = 1'b1;
                    go_mode     = MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        // mode change side effects
        if (go && (go_mode != mode_reg))
        begin
            mode_next = go_mode;
            if (go_mode == MODE_IDLE)
            begin
                rem_next   = dur_next;
                digit_next = '0;
            end
            else if (go_mode == MODE_LEARNING)
            begin
                rem_next = {{(VALUE_W - TO_W){1'b0}}, timeout_reg};
            end
            if (edited_next)
            begin
                edited_next = 1'b0;
                save_next   = 1'b1;
            end
        end
    end

    assign ram_we    = cmd.apply && tbl_we;
    assign ram_waddr = slot_next;
    assign ram_wdata = code_reg;
    assign ram_raddr = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dur_reg   <= MAX_DURATION_RST;
            timeout_reg   <= LEARN_TIMEOUT_RST;
            mode_reg      <= MODE_IDLE;
            dur_reg       <= '0;
            rem_reg       <= '0;
            digit_reg     <= '0;
            edited_reg    <= 1'b0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_DURATION:  max_dur_reg <= cfg_data;
                    REG_LEARN_TIMEOUT: timeout_reg <= cfg_data[TO_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            cmp_valid_reg <= cmd.search_step;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                match_reg <= 1'b0;
            end
            else if (cmd.search_step && (idx_reg != LAST_SLOT))
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (hit)
            begin
                match_reg <= 1'b1;
            end

            if (cmd.apply)
            begin
                mode_reg   <= mode_next;
                dur_reg    <= dur_next;
                rem_reg    <= rem_next;
                digit_reg  <= digit_next;
                edited_reg <= edited_next;
                slot_reg   <= slot_next;
                if (tbl_we)
                begin
                    valid_reg[slot_next] <= 1'b1;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_operation;
            code_reg <= in_frame_code;
        end
        if (cmd.search_step)
        begin
            cmp_last_reg     <= (idx_reg == LAST_SLOT);
            cmp_entry_ok_reg <= valid_reg[idx_reg];
        end
        if (cmd.apply)
        begin
            res_mode_reg  <= mode_next;
            res_value_reg <= (mode_next == MODE_IDLE || mode_next == MODE_SETTING)
                             ? dur_next : rem_next;
            res_digit_reg <= (mode_next == MODE_SETTING) ? digit_next : '0;
            res_save_reg  <= save_next;
            res_match_reg <= match_reg;
        end
    end

    assign out_mode         = res_mode_reg;
    assign out_shown_value  = res_value_reg;
    assign out_blink_digit  = res_digit_reg;
    assign out_save_request = res_save_reg;
    assign out_code_matched = res_match_reg;
endmodule

// ===== hdl/learned_remote_countdown_timer.sv =====
// Top level of the learned-remote countdown timer controller.
// Most events go through accept, apply and result valid in that order; a remote
//   code in idle first walks the learned-code table one entry a cycle through
//   the registered RAM read, stopping early when an entry matches.
// One item is in work at a time.
// Reset (rst_n, async low): idle mode, counts zero, config at defaults, all
//   table entries read as zero through per-entry valid bits; no clearing pass.
module learned_remote_countdown_timer import lrct_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    lrct_event_if.sink    events,
    lrct_result_if.source results,
    lrct_cfg_if.sink      cfg
);
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    lrct_cmd_t         cmd;
    lrct_status_t      st;

    // learned-code table port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [CODE_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [CODE_W-1:0] ram_rdata;

    // register writes are always taken; the user must send them only while idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    // sequencer: holds the event in the datapath while a result waits
    lrct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_ready  (events.ready),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .st        (st),
        .cmd       (cmd)
    );

    // all timer state, search compare and the result register
    lrct_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .in_operation     (events.operation),
        .in_frame_code    (events.frame_code),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.reg_index),
        .cfg_data         (cfg.wr_data),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata),
        .out_mode         (results.mode),
        .out_shown_value  (results.shown_value),
        .out_blink_digit  (results.blink_digit),
        .out_save_request (results.save_request),
        .out_code_matched (results.code_matched)
    );

    // learned codes; written round-robin in learning mode
    lrct_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a result is only loaded when the output register is free or being drained
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply && results.valid |-> results.ready)
        else $error("result register overwritten");

    // a match always starts the countdown
    a_match_works: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.code_matched |-> results.mode == MODE_WORKING)
        else $error("code match without working mode");

    // the edited digit is only shown while setting
    a_blink_setting: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.blink_digit != '0) |-> results.mode == MODE_SETTING)
        else $error("blink digit outside setting mode");

    // no new item while the search runs
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.search_step |-> !events.ready)
        else $error("input ready during table search");
endmodule
